[hdl/mdet_pkg.sv]
// ----------------------------------------------------------------------------
// mdet_pkg
// Types, widths and the permutation table shared by the 4x4 determinant unit.
// ----------------------------------------------------------------------------
package mdet_pkg;

   localparam int FIELD_WIDTH   = 16;
   localparam int DET_WIDTH     = 64;
   localparam int ELEM_WIDTH    = 16;
   localparam int FRAC_BITS     = 8;

   localparam int ROWS          = 4;
   localparam int COLUMNS       = 4;
   localparam int STORE_COLUMNS = COLUMNS - 1;
   localparam int COUNT_WIDTH   = $clog2(COLUMNS);
   localparam int ROW_WIDTH     = $clog2(ROWS);
   localparam logic [COUNT_WIDTH-1:0] LAST_COLUMN = COUNT_WIDTH'(COLUMNS - 1);

   localparam int PAIR_WIDTH    = 2 * ELEM_WIDTH;
   localparam int PROD_WIDTH    = 4 * ELEM_WIDTH;
   localparam int ACC_WIDTH     = 4 * ELEM_WIDTH + 2;
   localparam int SCALED_WIDTH  = ACC_WIDTH + 33;
   localparam int SCALE_SHIFT   = 32 - 4 * FRAC_BITS;
   localparam int LEFT_SHIFT    = (SCALE_SHIFT > 0) ? SCALE_SHIFT : 0;
   localparam int RIGHT_SHIFT   = (SCALE_SHIFT < 0) ? -SCALE_SHIFT : 0;

   localparam logic [DET_WIDTH-1:0] DET_MAX = {1'b0, {(DET_WIDTH-1){1'b1}}};
   localparam logic [DET_WIDTH-1:0] DET_MIN = {1'b1, {(DET_WIDTH-1){1'b0}}};

   localparam int TERM_COUNT    = 24;
   localparam int TERM_WIDTH    = $clog2(TERM_COUNT);

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef elem_type [ROWS-1:0]          column_type;
   typedef column_type [COLUMNS-1:0]     matrix_type;

   typedef struct packed {
      logic                 valid;
      matrix_type           matrix;
   } push_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
   } queue_status_type;

   // one term of the Leibniz expansion: row picked in each column, and parity
   typedef struct packed {
      logic                 neg;
      logic [ROW_WIDTH-1:0] row_c0;
      logic [ROW_WIDTH-1:0] row_c1;
      logic [ROW_WIDTH-1:0] row_c2;
      logic [ROW_WIDTH-1:0] row_c3;
   } perm_type;

   localparam logic [8:0] PERM_TABLE [TERM_COUNT] = '{
      9'b0_00_01_10_11, 9'b1_00_01_11_10, 9'b1_00_10_01_11, 9'b0_00_10_11_01,
      9'b0_00_11_01_10, 9'b1_00_11_10_01, 9'b1_01_00_10_11, 9'b0_01_00_11_10,
      9'b0_01_10_00_11, 9'b1_01_10_11_00, 9'b1_01_11_00_10, 9'b0_01_11_10_00,
      9'b0_10_00_01_11, 9'b1_10_00_11_01, 9'b1_10_01_00_11, 9'b0_10_01_11_00,
      9'b0_10_11_00_01, 9'b1_10_11_01_00, 9'b1_11_00_01_10, 9'b0_11_00_10_01,
      9'b0_11_01_00_10, 9'b1_11_01_10_00, 9'b1_11_10_00_01, 9'b0_11_10_01_00
   };

   function automatic perm_type perm_lookup(input logic [TERM_WIDTH-1:0] idx);
      return perm_type'(PERM_TABLE[idx]);
   endfunction

endpackage

[hdl/mdet_if.sv]
// ----------------------------------------------------------------------------
// mdet_req_if / mdet_rsp_if
// Valid/ready channels for matrix columns and determinant results.
// ----------------------------------------------------------------------------
interface mdet_req_if;
   import mdet_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] elem_row0;
   logic signed [FIELD_WIDTH-1:0] elem_row1;
   logic signed [FIELD_WIDTH-1:0] elem_row2;
   logic signed [FIELD_WIDTH-1:0] elem_row3;

   modport source (output valid, elem_row0, elem_row1, elem_row2, elem_row3,
                   input ready);
   modport sink   (input valid, elem_row0, elem_row1, elem_row2, elem_row3,
                   output ready);
endinterface

interface mdet_rsp_if;
   import mdet_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [DET_WIDTH-1:0] determinant;
   logic                        saturated;

   modport source (output valid, determinant, saturated, input ready);
   modport sink   (input valid, determinant, saturated, output ready);
endinterface

[hdl/mdet_front.sv]
// ----------------------------------------------------------------------------
// mdet_front
// Accepts columns, holds columns 0 to 2 and pushes each full matrix.
// ----------------------------------------------------------------------------
module mdet_front (
   input  logic                      clock,
   input  logic                      reset,
   mdet_req_if.sink                  req_chan,
   input  mdet_pkg::queue_status_type q_status,
   output mdet_pkg::push_type        push
);
   import mdet_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   column_type             store_ff [STORE_COLUMNS];
   column_type             col_in;
   logic                   last;
   logic                   accept;

   always_comb begin
      col_in[0] = req_chan.elem_row0[ELEM_WIDTH-1:0];
      col_in[1] = req_chan.elem_row1[ELEM_WIDTH-1:0];
      col_in[2] = req_chan.elem_row2[ELEM_WIDTH-1:0];
      col_in[3] = req_chan.elem_row3[ELEM_WIDTH-1:0];
   end

   assign last           = (count_ff == LAST_COLUMN);
   assign req_chan.ready = !last || !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = last ? '0 : count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !last) begin
         store_ff[count_ff] <= col_in;
      end
   end

   always_comb begin
      push.valid     = accept && last;
      push.matrix[0] = store_ff[0];
      push.matrix[1] = store_ff[1];
      push.matrix[2] = store_ff[2];
      push.matrix[3] = col_in;
   end

endmodule

[hdl/mdet_queue.sv]
// ----------------------------------------------------------------------------
// mdet_queue
// Two-entry matrix queue between the column front end and the compute engine.
// ----------------------------------------------------------------------------
module mdet_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  mdet_pkg::push_type         push,
   input  logic                       pop,
   output mdet_pkg::matrix_type       head,
   output mdet_pkg::queue_status_type q_status
);
   import mdet_pkg::*;

   matrix_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] cnt_ff;
   logic [QUEUE_CNT_WIDTH-1:0] cnt_in;
   logic                       do_push;
   logic                       do_pop;

   function automatic logic [QUEUE_PTR_WIDTH-1:0] next_ptr(
      input logic [QUEUE_PTR_WIDTH-1:0] ptr);
      return (ptr == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                         : ptr + QUEUE_PTR_WIDTH'(1);
   endfunction

   assign q_status.full  = (cnt_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign q_status.empty = (cnt_ff == '0);
   assign do_push        = push.valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QUEUE_CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.matrix;
      end
   end

endmodule

[hdl/mdet_back.sv]
// ----------------------------------------------------------------------------
// mdet_back
// Sums the 24 signed four-element products of one matrix through a shared
// multiplier pipeline, then scales to Q32.32 and saturates into the
// result register.
// ----------------------------------------------------------------------------
module mdet_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mdet_pkg::matrix_type       head,
   input  mdet_pkg::queue_status_type q_status,
   output logic                       pop,
   mdet_rsp_if.source                 rsp_chan
);
   import mdet_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                    state_ff;
   logic [1:0]                    state_in;
   logic [TERM_WIDTH-1:0]         term_ff;
   logic [TERM_WIDTH-1:0]         term_in;

   logic                          v1_ff;
   logic                          v1_in;
   logic                          neg1_ff;
   logic signed [PAIR_WIDTH-1:0]  pab_ff;
   logic signed [PAIR_WIDTH-1:0]  pab_in;
   logic signed [PAIR_WIDTH-1:0]  pcd_ff;
   logic signed [PAIR_WIDTH-1:0]  pcd_in;

   logic                          v2_ff;
   logic                          v2_in;
   logic                          neg2_ff;
   logic signed [PROD_WIDTH-1:0]  prod_ff;
   logic signed [PROD_WIDTH-1:0]  prod_in;

   logic signed [ACC_WIDTH-1:0]   acc_ff;
   logic signed [ACC_WIDTH-1:0]   acc_in;

   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [DET_WIDTH-1:0]          out_det_ff;
   logic [DET_WIDTH-1:0]          out_det_in;
   logic                          out_sat_ff;
   logic                          out_sat_in;

   perm_type                      perm;
   elem_type                      op_a;
   elem_type                      op_b;
   elem_type                      op_c;
   elem_type                      op_d;
   logic                          start;
   logic                          finish;
   logic signed [SCALED_WIDTH-1:0] scaled;
   logic                          fits;

   assign perm = perm_lookup(term_ff);
   assign op_a = head[0][perm.row_c0];
   assign op_b = head[1][perm.row_c1];
   assign op_c = head[2][perm.row_c2];
   assign op_d = head[3][perm.row_c3];

   assign start  = (state_ff == ST_IDLE) && !q_status.empty;
   assign finish = (state_ff == ST_DRAIN) && !v1_ff && !v2_ff
                   && (!out_valid_ff || rsp_chan.ready);
   assign pop    = finish;

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               term_in  = '0;
            end
         end
         ST_RUN: begin
            term_in = term_ff + TERM_WIDTH'(1);
            if (term_ff == TERM_WIDTH'(TERM_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      v1_in   = (state_ff == ST_RUN);
      pab_in  = op_a * op_b;
      pcd_in  = op_c * op_d;
      v2_in   = v1_ff;
      prod_in = pab_ff * pcd_ff;
      acc_in  = acc_ff;
      if (start) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = neg2_ff ? acc_ff - ACC_WIDTH'(prod_ff) : acc_ff + ACC_WIDTH'(prod_ff);
      end
   end

   always_comb begin
      scaled = (SCALED_WIDTH'(acc_ff) <<< LEFT_SHIFT) >>> RIGHT_SHIFT;
      fits   = (&scaled[SCALED_WIDTH-1:DET_WIDTH-1]) || !(|scaled[SCALED_WIDTH-1:DET_WIDTH-1]);
      out_det_in   = out_det_ff;
      out_sat_in   = out_sat_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (finish) begin
         out_valid_in = 1'b1;
         out_sat_in   = !fits;
         if (fits) begin
            out_det_in = scaled[DET_WIDTH-1:0];
         end else begin
            out_det_in = scaled[SCALED_WIDTH-1] ? DET_MIN : DET_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff    <= term_in;
      pab_ff     <= pab_in;
      pcd_ff     <= pcd_in;
      neg1_ff    <= perm.neg;
      prod_ff    <= prod_in;
      neg2_ff    <= neg1_ff;
      acc_ff     <= acc_in;
      out_det_ff <= out_det_in;
      out_sat_ff <= out_sat_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.determinant = out_det_ff;
   assign rsp_chan.saturated   = out_sat_ff;

endmodule

[hdl/matrix4_determinant_unit.sv]
// ----------------------------------------------------------------------------
// matrix4_determinant_unit
// Determinant of a 4x4 signed fixed-point matrix streamed column by column.
//
// req_chan carries one column per request (elem_row0..3, Q8.8), columns in
// order 0 to 3. After the fourth column one result leaves on rsp_chan: the
// determinant in Q32.32, saturated to 64 bits, with saturated set on clip.
// Columns are taken one per cycle, but a fourth column waits while the
// two-entry queue that holds full matrices is full. The compute engine runs
// one four-element product per cycle through a single shared multiplier
// pipeline, 24 products per matrix, and takes a new matrix from the queue
// only after it has finished the last one.
// When the receiver stalls, the result holds in the output register, the
// engine stops before writing its next result, and the queue then fills and
// the fourth column of the following matrix waits.
// Synchronous reset clears the column counter, the queue and the engine;
// held column data is not cleared.
// ----------------------------------------------------------------------------
module matrix4_determinant_unit (
   input  logic        clock,
   input  logic        reset,
   mdet_req_if.sink    req_chan,
   mdet_rsp_if.source  rsp_chan
);
   import mdet_pkg::*;

   push_type         push;
   queue_status_type q_status;
   matrix_type       head;
   logic             pop;

   mdet_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push)
   );

   mdet_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   mdet_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_status.full)
      else $error("matrix pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("matrix popped from empty queue");

   a_result_follows_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(pop))
      else $error("result raised without a finished matrix");

endmodule

[tb/mdet_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdet_tb_pkg
// Determinant scoreboard for the 4x4 determinant unit testbench. Accepted
// columns are collected into a matrix. On every fourth column the exact
// determinant is computed in 128 bits, scaled to Q32.32 and clipped. Results
// are then checked in order against the queued predictions.
// ----------------------------------------------------------------------------
package mdet_tb_pkg;
   import mdet_pkg::*;

   typedef struct {
      logic signed [DET_WIDTH-1:0] determinant;
      logic                        saturated;
   } det_expect_type;

   class determinant_scoreboard;
      column_type     held_cols [STORE_COLUMNS];
      int unsigned    next_col;
      det_expect_type expected_dets [$];
      int unsigned    columns_seen;
      int unsigned    dets_checked;
      int unsigned    sat_seen;
      int unsigned    error_count;

      function new();
         next_col     = 0;
         columns_seen = 0;
         dets_checked = 0;
         sat_seen     = 0;
         error_count  = 0;
      endfunction

      // sign-extend the low ELEM_WIDTH bits; upper field bits are don't-care
      function logic signed [127:0] widen_elem(logic [FIELD_WIDTH-1:0] raw);
         logic signed [ELEM_WIDTH-1:0] low;
         low = raw[ELEM_WIDTH-1:0];
         return low;
      endfunction

      function det_expect_type predict_det(column_type last_col);
         logic signed [127:0] a [ROWS][COLUMNS];
         logic signed [127:0] minor_val;
         logic signed [127:0] acc;
         logic signed [127:0] lim_hi;
         logic signed [127:0] lim_lo;
         int                  s [3];
         int                  k;
         int                  shift;
         det_expect_type      res;
         for (int c = 0; c < COLUMNS; c++) begin
            for (int r = 0; r < ROWS; r++) begin
               a[r][c] = widen_elem((c < STORE_COLUMNS) ? held_cols[c][r] : last_col[r]);
            end
         end
         // cofactor expansion along column 0, exact
         acc = '0;
         for (int r = 0; r < ROWS; r++) begin
            k = 0;
            for (int rr = 0; rr < ROWS; rr++) begin
               if (rr != r) begin
                  s[k] = rr;
                  k++;
               end
            end
            minor_val = a[s[0]][1] * (a[s[1]][2] * a[s[2]][3] - a[s[1]][3] * a[s[2]][2])
                      - a[s[0]][2] * (a[s[1]][1] * a[s[2]][3] - a[s[1]][3] * a[s[2]][1])
                      + a[s[0]][3] * (a[s[1]][1] * a[s[2]][2] - a[s[1]][2] * a[s[2]][1]);
            if (r % 2 == 1) acc = acc - a[r][0] * minor_val;
            else            acc = acc + a[r][0] * minor_val;
         end
         shift = 32 - 4 * FRAC_BITS;
         if (shift > 0)      acc = acc <<< shift;
         else if (shift < 0) acc = acc >>> (-shift);
         lim_hi = 128'sh7FFF_FFFF_FFFF_FFFF;
         lim_lo = -lim_hi - 1;
         if (acc > lim_hi) begin
            res.determinant = DET_MAX;
            res.saturated   = 1'b1;
         end else if (acc < lim_lo) begin
            res.determinant = DET_MIN;
            res.saturated   = 1'b1;
         end else begin
            res.determinant = acc[DET_WIDTH-1:0];
            res.saturated   = 1'b0;
         end
         return res;
      endfunction

      function void note_column(column_type col);
         columns_seen++;
         if (next_col < STORE_COLUMNS) begin
            held_cols[next_col] = col;
            next_col++;
         end else begin
            expected_dets.push_back(predict_det(col));
            next_col = 0;
         end
      endfunction

      function void check_result(logic signed [DET_WIDTH-1:0] det, logic sat);
         det_expect_type want;
         if (expected_dets.size() == 0) begin
            $display("%0t: unexpected result determinant=%h saturated=%b", $time, det, sat);
            error_count++;
            return;
         end
         want = expected_dets.pop_front();
         dets_checked++;
         if (want.saturated) sat_seen++;
         if (det !== want.determinant) begin
            $display("%0t: determinant mismatch: expected %h, actual %h",
                     $time, want.determinant, det);
            error_count++;
         end
         if (sat !== want.saturated) begin
            $display("%0t: saturated mismatch: expected %b, actual %b",
                     $time, want.saturated, sat);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_dets.size();
      endfunction
   endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for matrix4_determinant_unit. Directed matrices cover identity,
// Hadamard-type matrices that clip in both directions, extreme and singular
// cases. Random matrices follow, with bursty requests, a patterned result
// stall and one long hold-off that backs up the unit.
// ----------------------------------------------------------------------------
module tb_top;
   import mdet_pkg::*;
   import mdet_tb_pkg::*;

   localparam int HOLDOFF_CYCLES  = 300;
   localparam int IDLE_LIMIT      = 2000;
   localparam int RANDOM_MATRICES = 300;
   localparam int DRAIN_CYCLES    = 40;

   localparam logic [FIELD_WIDTH-1:0] EXTREME_VALUES [8] = '{
      16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE, 16'h0100
   };

   typedef enum {
      MAT_RANDOM, MAT_SMALL, MAT_EXTREME, MAT_HADAMARD, MAT_SINGULAR
   } matrix_kind_type;

   typedef enum {
      DIR_IDENTITY, DIR_HADAMARD_POS, DIR_HADAMARD_NEG, DIR_ALL_MIN, DIR_DIAG_EXTREME,
      DIR_CHECKER, DIR_COUNT
   } directed_type;

   logic clock = 1'b0;
   logic reset;

   mdet_req_if req ();
   mdet_rsp_if rsp ();

   matrix4_determinant_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   determinant_scoreboard sb = new();

   int unsigned burst_left  = 0;
   int unsigned idle_cycles = 0;
   bit          held_off    = 1'b0;
   column_type  seen_col;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         seen_col[0] = req.elem_row0;
         seen_col[1] = req.elem_row1;
         seen_col[2] = req.elem_row2;
         seen_col[3] = req.elem_row3;
         sb.note_column(seen_col);
      end
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result(rsp.determinant, rsp.saturated);
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: patterned stalls, one long hold-off once results flow
   initial begin
      logic [7:0] pattern;
      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && sb.dets_checked >= 20) begin
            rsp.ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end
         pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         for (int i = 0; i < 64; i++) begin
            rsp.ready <= pattern[i % 8];
            @(posedge clock);
         end
      end
   end

   task automatic send_column(column_type col);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
      end
      burst_left--;
      req.valid     <= 1'b1;
      req.elem_row0 <= col[0];
      req.elem_row1 <= col[1];
      req.elem_row2 <= col[2];
      req.elem_row3 <= col[3];
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic send_matrix(matrix_type mt);
      for (int c = 0; c < COLUMNS; c++) send_column(mt[c]);
   endtask

   function automatic matrix_type directed_matrix(directed_type kind);
      matrix_type mt;
      int         cc;
      for (int c = 0; c < COLUMNS; c++) begin
         for (int r = 0; r < ROWS; r++) begin
            cc = (c == 2) ? 3 : (c == 3) ? 2 : c;
            case (kind)
               DIR_IDENTITY:     mt[c][r] = (r == c) ? 16'sh0100 : 16'sh0000;
               DIR_HADAMARD_POS: mt[c][r] = ($countones(r & c) % 2) ? -16'sd32767 : 16'sd32767;
               DIR_HADAMARD_NEG: mt[c][r] = ($countones(r & cc) % 2) ? -16'sd32767 : 16'sd32767;
               DIR_ALL_MIN:      mt[c][r] = 16'sh8000;
               DIR_DIAG_EXTREME: mt[c][r] = (r != c) ? 16'sh0000 :
                                            (r % 2) ? 16'sh7FFF : 16'sh8000;
               default:          mt[c][r] = (r == 3) ? 16'shFFFF :
                                            ((r + c) % 2) ? 16'sh8000 : 16'sh7FFF;
            endcase
         end
      end
      return mt;
   endfunction

   function automatic matrix_type random_matrix();
      matrix_type      mt;
      matrix_kind_type kind;
      int              pick;
      int              mag;
      int              src;
      int              dst;
      logic [3:0]      rflip;
      logic [3:0]      cflip;
      pick  = $urandom_range(0, 99);
      kind  = (pick < 35) ? MAT_RANDOM : (pick < 55) ? MAT_SMALL :
              (pick < 70) ? MAT_EXTREME : (pick < 90) ? MAT_HADAMARD : MAT_SINGULAR;
      rflip = 4'($urandom);
      cflip = 4'($urandom);
      for (int c = 0; c < COLUMNS; c++) begin
         for (int r = 0; r < ROWS; r++) begin
            case (kind)
               MAT_SMALL:   mt[c][r] = elem_type'(int'($urandom_range(0, 2047)) - 1024);
               MAT_EXTREME: mt[c][r] = EXTREME_VALUES[$urandom_range(0, 7)];
               MAT_HADAMARD: begin
                  mag = $urandom_range(30000, 32767);
                  if (($countones(r & c) + rflip[r] + cflip[c]) % 2 == 1)
                     mt[c][r] = elem_type'(-mag - int'($urandom_range(0, 1)));
                  else
                     mt[c][r] = elem_type'(mag);
               end
               default:     mt[c][r] = elem_type'($urandom_range(0, 65535));
            endcase
         end
      end
      if (kind == MAT_SINGULAR) begin
         src     = $urandom_range(0, 3);
         dst     = (src + $urandom_range(1, 3)) % 4;
         mt[dst] = mt[src];
      end
      return mt;
   endfunction

   initial begin
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.elem_row0 <= '0;
      req.elem_row1 <= '0;
      req.elem_row2 <= '0;
      req.elem_row3 <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int d = 0; d < DIR_COUNT; d++) send_matrix(directed_matrix(directed_type'(d)));
      for (int m = 0; m < RANDOM_MATRICES; m++) send_matrix(random_matrix());
      req.valid <= 1'b0;
      // let the monitor record the last accepted column first
      @(posedge clock);

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d columns and %0d determinants (%0d clipped), long hold-off %s",
               sb.columns_seen, sb.dets_checked, sb.sat_seen, held_off ? "done" : "not reached");
      $display("Mismatches: %0d", sb.error_count);
      if (sb.error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
